>>> design/lsnd_pkg.sv
`timescale 1ns / 1ps

package lsnd_pkg;

  localparam int unsigned WindowKeep = 4;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned QualityW  = 6;
  localparam int unsigned AngleW    = 15;
  localparam int unsigned DistanceW = 16;

  // 360 degrees in 1/64 degree steps
  localparam logic [AngleW-1:0] FullCircleQ6 = AngleW'(23040);

  typedef logic [ByteW-1:0] byte_t;

  // oldest byte at index 0
  typedef logic [WindowKeep-1:0][ByteW-1:0] window_t;

  typedef struct packed {
    logic                 hit;
    logic                 scan_start;
    logic [QualityW-1:0]  quality;
    logic [AngleW-1:0]    angle_q6;
    logic [DistanceW-1:0] distance_q2;
  } node_t;

endpackage

>>> design/lsnd_cell.sv
`timescale 1ns / 1ps

module lsnd_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  logic            clear_i,
  input  lsnd_pkg::byte_t byte_i,
  input  logic            valid_i,
  output lsnd_pkg::byte_t byte_o,
  output logic            valid_o
);
  import lsnd_pkg::*;

  byte_t byte_q, byte_d;
  logic  valid_q, valid_d;

  always_comb begin
    byte_d  = byte_q;
    valid_d = valid_q;
    if (shift_i) begin
      byte_d  = byte_i;
      valid_d = valid_i;
    end
    // a decoded frame empties the whole window
    if (clear_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

>>> design/lsnd_check.sv
`timescale 1ns / 1ps

module lsnd_check (
  input  logic              full_i,
  input  lsnd_pkg::window_t win_i,
  input  lsnd_pkg::byte_t   rx_byte_i,
  output lsnd_pkg::node_t   node_o
);
  import lsnd_pkg::*;

  byte_t             b0, b1, b2, b3;
  logic [AngleW-1:0] raw_angle;

  assign b0 = win_i[0];
  assign b1 = win_i[1];
  assign b2 = win_i[2];
  assign b3 = win_i[3];

  assign raw_angle = {b2, b1[ByteW-1:1]};

  always_comb begin
    node_o.hit         = full_i && (b0[0] != b0[1]) && b1[0];
    node_o.scan_start  = b0[0];
    node_o.quality     = b0[ByteW-1:2];
    // raw stays below twice a full circle, one subtract wraps it
    node_o.angle_q6    = (raw_angle >= FullCircleQ6) ? (raw_angle - FullCircleQ6) : raw_angle;
    node_o.distance_q2 = {rx_byte_i, b3};
  end

endmodule

>>> design/lidar_scan_node_deframer_unit.sv
`timescale 1ns / 1ps

// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   rx_byte_i
// out      output     out_valid_o / out_stall_i new_scan_o, quality_o, angle_q6_o, distance_q2_o
//
// one byte is taken per cycle unless in is stalled; every byte shifts the four-cell window by one
// a node comes out in the cycle after its fifth byte is taken, from the output register
// the input stalls only while a node waits in the output register and out is stalled
// reset empties the window and the output register

module lidar_scan_node_deframer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lsnd_pkg::byte_t                rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           new_scan_o,
  output logic [lsnd_pkg::QualityW-1:0]  quality_o,
  output logic [lsnd_pkg::AngleW-1:0]    angle_q6_o,
  output logic [lsnd_pkg::DistanceW-1:0] distance_q2_o
);
  import lsnd_pkg::*;

  window_t               win;
  logic [WindowKeep-1:0] win_vld;
  logic                  in_acc;
  node_t                 node;

  logic                 out_valid_q, out_valid_d;
  logic                 new_scan_q;
  logic [QualityW-1:0]  quality_q;
  logic [AngleW-1:0]    angle_q;
  logic [DistanceW-1:0] distance_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  for (genvar i = 0; i < WindowKeep; i++) begin : g_cell
    if (i == WindowKeep - 1) begin : g_tail
      lsnd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (in_acc),
        .clear_i (in_acc && node.hit),
        .byte_i  (rx_byte_i),
        .valid_i (1'b1),
        .byte_o  (win[i]),
        .valid_o (win_vld[i])
      );
    end else begin : g_body
      lsnd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (in_acc),
        .clear_i (in_acc && node.hit),
        .byte_i  (win[i+1]),
        .valid_i (win_vld[i+1]),
        .byte_o  (win[i]),
        .valid_o (win_vld[i])
      );
    end
  end

  // oldest cell holds a byte only once the window is full
  lsnd_check u_check (
    .full_i    (win_vld[0]),
    .win_i     (win),
    .rx_byte_i (rx_byte_i),
    .node_o    (node)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (in_acc && node.hit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && node.hit) begin
      new_scan_q <= node.scan_start;
      quality_q  <= node.quality;
      angle_q    <= node.angle_q6;
      distance_q <= node.distance_q2;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign new_scan_o    = new_scan_q;
  assign quality_o     = quality_q;
  assign angle_q6_o    = angle_q;
  assign distance_q2_o = distance_q;

`ifndef SYNTHESIS
  a_angle_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (angle_q6_o < FullCircleQ6))
    else $error("angle not wrapped below a full circle");

  a_no_hit_before_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !win_vld[0] |-> !node.hit)
    else $error("frame decoded from a partial window");

  a_hit_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && node.hit) |=> (out_valid_o && (win_vld == '0)))
    else $error("decoded frame did not empty window or raise output");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("byte taken while output register blocked");
`endif

endmodule
